FILE: src/cbpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block pool allocator package
// Shared widths, status and register codes, and the memory control bundle.
// ----------------------------------------------------------------------------
package cbpa_pkg;

  localparam int unsigned ADDR_W     = 22;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned PAYLOAD_W  = 12;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned LINE_SHIFT = 6;
  localparam int unsigned DIV_W      = ADDR_W - LINE_SHIFT;
  localparam int unsigned DIV_STEPS  = 4;

  localparam int unsigned DEFAULT_CAPACITY     = 1024;
  localparam int unsigned DEFAULT_GROW_BATCH   = 32;
  localparam int unsigned DEFAULT_HEADER_BYTES = 64;
  localparam int unsigned RESET_PAYLOAD_BYTES  = 64;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 3'd4;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_BLOCKS = 2'd2;

  typedef struct packed {
    logic link_re;
    logic link_we;
    logic mark_re;
    logic mark_we;
    logic mark_wdata;
  } mem_ctl_t;

endpackage
`default_nettype wire

FILE: src/cbpa_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbpa_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cbpa_pkg::CFG_IDX_W-1:0]   index;
  logic [cbpa_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: src/cbpa_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// One allocate or free request per transaction.
// ----------------------------------------------------------------------------
interface cbpa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [cbpa_pkg::SIZE_W-1:0]   request_size;
  logic [cbpa_pkg::ADDR_W-1:0]   address;

  modport source (output valid, output action, output request_size, output address,
                  input ready);
  modport sink (input valid, input action, input request_size, input address,
                output ready);
endinterface
`default_nettype wire

FILE: src/cbpa_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Status, allocated address and pool counts, one transaction per request.
// ----------------------------------------------------------------------------
interface cbpa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [cbpa_pkg::STATUS_W-1:0]  status;
  logic [cbpa_pkg::ADDR_W-1:0]    block_address;
  logic [cbpa_pkg::COUNT_W-1:0]   free_blocks;
  logic [cbpa_pkg::COUNT_W-1:0]   in_use_blocks;
  logic [cbpa_pkg::COUNT_W-1:0]   provisioned_blocks;

  modport source (output valid, output status, output block_address, output free_blocks,
                  output in_use_blocks, output provisioned_blocks, input ready);
  modport sink (input valid, input status, input block_address, input free_blocks,
                input in_use_blocks, input provisioned_blocks, output ready);
endinterface
`default_nettype wire

FILE: src/cbpa_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stride quotient divider
// Restoring divider that resolves several quotient bits per cycle.
// ----------------------------------------------------------------------------
module cbpa_div #(
  parameter int unsigned DIVISOR_W = 7
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [cbpa_pkg::DIV_W-1:0]   dividend_i,
  input  wire logic [DIVISOR_W-1:0]         divisor_i,
  output logic                              done_o,
  output logic [cbpa_pkg::DIV_W-1:0]        quotient_o,
  output logic [DIVISOR_W-1:0]              remainder_o
);

  localparam int unsigned ITER  = cbpa_pkg::DIV_W / cbpa_pkg::DIV_STEPS;
  localparam int unsigned ITER_W = $clog2(ITER);

  logic                         active_q, active_d;
  logic                         done_q, done_d;
  logic [ITER_W-1:0]            cnt_q, cnt_d;
  logic [cbpa_pkg::DIV_W-1:0]   quo_q, quo_d;
  logic [DIVISOR_W-1:0]         rem_q, rem_d;
  logic [DIVISOR_W-1:0]         divisor_q, divisor_d;

  always_comb begin
    logic [DIVISOR_W:0]         cand;
    logic [DIVISOR_W-1:0]       rem;
    logic [cbpa_pkg::DIV_W-1:0] quo;
    cand      = '0;
    active_d  = active_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    divisor_d = divisor_q;
    rem       = rem_q;
    quo       = quo_q;
    if (start_i) begin
      active_d  = 1'b1;
      cnt_d     = '0;
      divisor_d = divisor_i;
      rem       = '0;
      quo       = dividend_i;
    end else if (active_q) begin
      for (int unsigned s = 0; s < cbpa_pkg::DIV_STEPS; s++) begin
        cand = {rem, quo[cbpa_pkg::DIV_W-1]};
        quo  = {quo[cbpa_pkg::DIV_W-2:0], 1'b0};
        if (cand >= {1'b0, divisor_q}) begin
          cand   = cand - {1'b0, divisor_q};
          quo[0] = 1'b1;
        end
        rem = cand[DIVISOR_W-1:0];
      end
      cnt_d = cnt_q + ITER_W'(1);
      if (cnt_q == ITER_W'(ITER - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
    rem_d = rem;
    quo_d = quo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule
`default_nettype wire

FILE: src/cbpa_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block state store
// Link memory of the freed stack and allocated-mark memory, with the mark
// clearing sweep that runs after reset and after each pool restart.
// ----------------------------------------------------------------------------
module cbpa_store #(
  parameter int unsigned CAPACITY = cbpa_pkg::DEFAULT_CAPACITY,
  parameter int unsigned IDX_W    = $clog2(CAPACITY)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               clear_i,
  output logic                    busy_o,
  input  wire cbpa_pkg::mem_ctl_t ctl_i,
  input  wire logic [IDX_W-1:0]   addr_i,
  input  wire logic [IDX_W-1:0]   link_wdata_i,
  output logic [IDX_W-1:0]        link_rdata_o,
  output logic                    mark_rdata_o
);

  logic [IDX_W-1:0] link_mem [CAPACITY];
  logic             mark_mem [CAPACITY];

  logic             busy_q, busy_d;
  logic [IDX_W-1:0] sweep_q, sweep_d;
  logic [IDX_W-1:0] link_rdata_q;
  logic             mark_rdata_q;
  logic             mark_we;
  logic             mark_wdata;
  logic [IDX_W-1:0] mark_addr;

  always_comb begin
    busy_d  = busy_q;
    sweep_d = sweep_q;
    if (clear_i) begin
      busy_d  = 1'b1;
      sweep_d = '0;
    end else if (busy_q) begin
      sweep_d = sweep_q + IDX_W'(1);
      if (sweep_q == IDX_W'(CAPACITY - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  assign mark_we    = busy_q | ctl_i.mark_we;
  assign mark_wdata = busy_q ? 1'b0 : ctl_i.mark_wdata;
  assign mark_addr  = busy_q ? sweep_q : addr_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      sweep_q <= '0;
    end else begin
      busy_q  <= busy_d;
      sweep_q <= sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.link_we) begin
      link_mem[addr_i] <= link_wdata_i;
    end
    if (ctl_i.link_re) begin
      link_rdata_q <= link_mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_addr] <= mark_wdata;
    end
    if (ctl_i.mark_re) begin
      mark_rdata_q <= mark_mem[addr_i];
    end
  end

  assign busy_o       = busy_q;
  assign link_rdata_o = link_rdata_q;
  assign mark_rdata_o = mark_rdata_q;

endmodule
`default_nettype wire

FILE: src/checked_block_pool_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Checked block pool allocator
// Fixed-size block pool with a LIFO free stack, lazy growth and checked frees.
// ----------------------------------------------------------------------------
// The block handles one request at a time and takes the next one while the
// previous response still waits on the response channel. An allocate goes
// through one memory access for the stack pop and mark, one multiply by the
// stride, one add of the header, and the response register. A free goes
// through the stride divider, which resolves four quotient bits a cycle, and
// a read of the allocated-mark memory; a free whose quotient is out of range
// or inexact skips the read. An oversize or exhausted allocate, and a free
// below the header or off the line grid, go straight to the response. After
// reset and after every write to a defined register the mark memory is swept
// clear, one entry per cycle, and requests are held off until the sweep ends;
// configuration transactions are always taken.
// ----------------------------------------------------------------------------
module checked_block_pool_allocator #(
  parameter int unsigned CAPACITY     = cbpa_pkg::DEFAULT_CAPACITY,
  parameter int unsigned GROW_BATCH   = cbpa_pkg::DEFAULT_GROW_BATCH,
  parameter int unsigned HEADER_BYTES = cbpa_pkg::DEFAULT_HEADER_BYTES
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cbpa_cfg_if.sink    cfg_i,
  cbpa_req_if.sink    req_i,
  cbpa_rsp_if.source  rsp_o
);

  localparam int unsigned IDX_W       = $clog2(CAPACITY);
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
  localparam int unsigned LINE_ROUND  = (1 << cbpa_pkg::LINE_SHIFT) - 1;
  localparam int unsigned LINES_MAX   =
      (HEADER_BYTES + (1 << cbpa_pkg::PAYLOAD_W) - 1 + LINE_ROUND) >> cbpa_pkg::LINE_SHIFT;
  localparam int unsigned LINES_W     = $clog2(LINES_MAX + 1);
  localparam int unsigned RESET_LINES =
      (HEADER_BYTES + cbpa_pkg::RESET_PAYLOAD_BYTES + LINE_ROUND) >> cbpa_pkg::LINE_SHIFT;
  localparam int unsigned PROD_W      = IDX_W + LINES_W;
  localparam int unsigned SUM_RAW_W   = PROD_W + cbpa_pkg::LINE_SHIFT + 1;
  localparam int unsigned SUM_W       =
      (SUM_RAW_W > cbpa_pkg::ADDR_W) ? SUM_RAW_W : cbpa_pkg::ADDR_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_ADDR = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_CHK  = 7'b0100000,
    S_RESP = 7'b1000000
  } state_e;

  state_e                          state_q, state_d;
  logic [cbpa_pkg::PAYLOAD_W-1:0]  payload_q, payload_d;
  logic [cbpa_pkg::COUNT_W-1:0]    blimit_q, blimit_d;
  logic [cbpa_pkg::COUNT_W-1:0]    init_q, init_d;
  logic                            restart_q, restart_d;
  logic [LINES_W-1:0]              lines_q, lines_d;
  logic [CNT_W-1:0]                limit_q, limit_d;

  logic [IDX_W-1:0]                head_q, head_d;
  logic [CNT_W-1:0]                depth_q, depth_d;
  logic [CNT_W-1:0]                fresh_q, fresh_d;
  logic [CNT_W-1:0]                prov_q, prov_d;
  logic [CNT_W-1:0]                free_q, free_d;

  logic                            action_q, action_d;
  logic [cbpa_pkg::SIZE_W-1:0]     size_q, size_d;
  logic [cbpa_pkg::ADDR_W-1:0]     addr_q, addr_d;
  logic [IDX_W-1:0]                idx_q, idx_d;
  logic                            pop_q, pop_d;
  logic [PROD_W-1:0]               prod_q, prod_d;
  logic [cbpa_pkg::STATUS_W-1:0]   res_status_q, res_status_d;
  logic [cbpa_pkg::ADDR_W-1:0]     res_addr_q, res_addr_d;

  logic                            out_valid_q, out_valid_d;
  logic [cbpa_pkg::STATUS_W-1:0]   out_status_q, out_status_d;
  logic [cbpa_pkg::ADDR_W-1:0]     out_addr_q, out_addr_d;
  logic [cbpa_pkg::COUNT_W-1:0]    out_free_q, out_free_d;
  logic [cbpa_pkg::COUNT_W-1:0]    out_inuse_q, out_inuse_d;
  logic [cbpa_pkg::COUNT_W-1:0]    out_prov_q, out_prov_d;

  cbpa_pkg::mem_ctl_t              mem_ctl;
  logic [IDX_W-1:0]                mem_addr;
  logic [IDX_W-1:0]                link_rdata;
  logic                            mark_rdata;
  logic                            clr_busy;

  logic                            div_start;
  logic                            div_done;
  logic [cbpa_pkg::DIV_W-1:0]      div_quo;
  logic [LINES_W-1:0]              div_rem;

  logic                            cfg_fire;
  logic                            req_fire;
  logic [cbpa_pkg::ADDR_W-1:0]     offset;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;
  assign req_i.ready = (state_q == S_IDLE) && !clr_busy && !restart_q;
  assign req_fire    = req_i.valid && req_i.ready;
  assign offset      = addr_q - cbpa_pkg::ADDR_W'(HEADER_BYTES);

  always_comb begin
    payload_d = payload_q;
    blimit_d  = blimit_q;
    init_d    = init_q;
    restart_d = 1'b0;
    if (cfg_fire) begin
      unique case (cfg_i.index)
        cbpa_pkg::CFG_PAYLOAD_BYTES: begin
          payload_d = cfg_i.data;
          restart_d = 1'b1;
        end
        cbpa_pkg::CFG_BLOCK_LIMIT: begin
          blimit_d  = cfg_i.data[cbpa_pkg::COUNT_W-1:0];
          restart_d = 1'b1;
        end
        cbpa_pkg::CFG_INITIAL_BLOCKS: begin
          init_d    = cfg_i.data[cbpa_pkg::COUNT_W-1:0];
          restart_d = 1'b1;
        end
        default: begin
          restart_d = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] clip;
    logic [CNT_W-1:0] room;
    logic [CNT_W-1:0] grow;
    logic             grow_en;
    logic [CNT_W-1:0] grow_amt;
    logic [CNT_W-1:0] prov_grown;
    logic [SUM_W-1:0] sum;

    state_d      = state_q;
    lines_d      = lines_q;
    limit_d      = limit_q;
    head_d       = head_q;
    depth_d      = depth_q;
    fresh_d      = fresh_q;
    prov_d       = prov_q;
    free_d       = free_q;
    action_d     = action_q;
    size_d       = size_q;
    addr_d       = addr_q;
    idx_d        = idx_q;
    pop_d        = pop_q;
    prod_d       = prod_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    out_free_d   = out_free_q;
    out_inuse_d  = out_inuse_q;
    out_prov_d   = out_prov_q;
    mem_ctl      = '0;
    mem_addr     = idx_q;
    div_start    = 1'b0;

    if (blimit_q == '0 || 32'(blimit_q) > 32'(CAPACITY)) begin
      lim = CNT_W'(CAPACITY);
    end else begin
      lim = CNT_W'(blimit_q);
    end
    clip = (32'(init_q) < 32'(lim)) ? CNT_W'(init_q) : lim;

    room       = limit_q - prov_q;
    grow       = (32'(room) > 32'(GROW_BATCH)) ? CNT_W'(GROW_BATCH) : room;
    grow_en    = (depth_q == '0) && (fresh_q >= prov_q) && (prov_q < limit_q);
    grow_amt   = grow_en ? grow : '0;
    prov_grown = prov_q + grow_amt;

    sum = (SUM_W'(prod_q) << cbpa_pkg::LINE_SHIFT) + SUM_W'(HEADER_BYTES);

    if (restart_q) begin
      lines_d = LINES_W'((32'(HEADER_BYTES) + 32'(payload_q) + 32'(LINE_ROUND))
                         >> cbpa_pkg::LINE_SHIFT);
      limit_d = lim;
      head_d  = '0;
      depth_d = '0;
      fresh_d = '0;
      prov_d  = clip;
      free_d  = clip;
    end

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          action_d = req_i.action;
          size_d   = req_i.request_size;
          addr_d   = req_i.address;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (action_q == cbpa_pkg::ACT_ALLOC) begin
          if (size_q > cbpa_pkg::SIZE_W'(payload_q)) begin
            res_status_d = cbpa_pkg::ST_TOO_LARGE;
            res_addr_d   = '0;
            state_d      = S_RESP;
          end else if (depth_q != '0) begin
            mem_ctl.link_re    = 1'b1;
            mem_ctl.mark_we    = 1'b1;
            mem_ctl.mark_wdata = 1'b1;
            mem_addr           = head_q;
            idx_d              = head_q;
            pop_d              = 1'b1;
            depth_d            = depth_q - CNT_W'(1);
            free_d             = free_q - CNT_W'(1);
            state_d            = S_MUL;
          end else if (fresh_q < prov_grown) begin
            mem_ctl.mark_we    = 1'b1;
            mem_ctl.mark_wdata = 1'b1;
            mem_addr           = fresh_q[IDX_W-1:0];
            idx_d              = fresh_q[IDX_W-1:0];
            pop_d              = 1'b0;
            fresh_d            = fresh_q + CNT_W'(1);
            prov_d             = prov_grown;
            free_d             = free_q + grow_amt - CNT_W'(1);
            state_d            = S_MUL;
          end else begin
            res_status_d = cbpa_pkg::ST_EXHAUSTED;
            res_addr_d   = '0;
            state_d      = S_RESP;
          end
        end else begin
          res_addr_d = '0;
          if (32'(addr_q) < 32'(HEADER_BYTES) ||
              offset[cbpa_pkg::LINE_SHIFT-1:0] != '0) begin
            res_status_d = cbpa_pkg::ST_BAD_ADDR;
            state_d      = S_RESP;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_MUL: begin
        if (pop_q) begin
          head_d = link_rdata;
        end
        prod_d  = PROD_W'(idx_q) * PROD_W'(lines_q);
        state_d = S_ADDR;
      end
      S_ADDR: begin
        res_status_d = cbpa_pkg::ST_OK;
        res_addr_d   = sum[cbpa_pkg::ADDR_W-1:0];
        state_d      = S_RESP;
      end
      S_DIV: begin
        if (div_done) begin
          if (div_rem != '0 || 32'(div_quo) >= 32'(prov_q)) begin
            res_status_d = cbpa_pkg::ST_BAD_ADDR;
            state_d      = S_RESP;
          end else begin
            mem_ctl.mark_re = 1'b1;
            mem_addr        = div_quo[IDX_W-1:0];
            idx_d           = div_quo[IDX_W-1:0];
            state_d         = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (!mark_rdata) begin
          res_status_d = cbpa_pkg::ST_DOUBLE_FREE;
        end else begin
          mem_ctl.mark_we    = 1'b1;
          mem_ctl.mark_wdata = 1'b0;
          mem_ctl.link_we    = 1'b1;
          head_d             = idx_q;
          depth_d            = depth_q + CNT_W'(1);
          free_d             = free_q + CNT_W'(1);
          res_status_d       = cbpa_pkg::ST_OK;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
          out_free_d   = cbpa_pkg::COUNT_W'(free_q);
          out_inuse_d  = cbpa_pkg::COUNT_W'(prov_q - free_q);
          out_prov_d   = cbpa_pkg::COUNT_W'(prov_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      payload_q   <= cbpa_pkg::PAYLOAD_W'(cbpa_pkg::RESET_PAYLOAD_BYTES);
      blimit_q    <= '0;
      init_q      <= '0;
      restart_q   <= 1'b0;
      lines_q     <= LINES_W'(RESET_LINES);
      limit_q     <= CNT_W'(CAPACITY);
      head_q      <= '0;
      depth_q     <= '0;
      fresh_q     <= '0;
      prov_q      <= '0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      payload_q   <= payload_d;
      blimit_q    <= blimit_d;
      init_q      <= init_d;
      restart_q   <= restart_d;
      lines_q     <= lines_d;
      limit_q     <= limit_d;
      head_q      <= head_d;
      depth_q     <= depth_d;
      fresh_q     <= fresh_d;
      prov_q      <= prov_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q     <= action_d;
    size_q       <= size_d;
    addr_q       <= addr_d;
    idx_q        <= idx_d;
    pop_q        <= pop_d;
    prod_q       <= prod_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
    out_free_q   <= out_free_d;
    out_inuse_q  <= out_inuse_d;
    out_prov_q   <= out_prov_d;
  end

  cbpa_store #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (restart_q),
    .busy_o       (clr_busy),
    .ctl_i        (mem_ctl),
    .addr_i       (mem_addr),
    .link_wdata_i (head_q),
    .link_rdata_o (link_rdata),
    .mark_rdata_o (mark_rdata)
  );

  cbpa_div #(
    .DIVISOR_W (LINES_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (offset[cbpa_pkg::ADDR_W-1:cbpa_pkg::LINE_SHIFT]),
    .divisor_i   (lines_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign rsp_o.valid              = out_valid_q;
  assign rsp_o.status             = out_status_q;
  assign rsp_o.block_address      = out_addr_q;
  assign rsp_o.free_blocks        = out_free_q;
  assign rsp_o.in_use_blocks      = out_inuse_q;
  assign rsp_o.provisioned_blocks = out_prov_q;

endmodule
`default_nettype wire

FILE: test/cbpa_pool_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool allocator checker
// Watches the configuration, request and response channels, keeps its own
// model of the pool and compares every response with the predicted one.
// ----------------------------------------------------------------------------
module cbpa_pool_checker
  import cbpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  cbpa_cfg_if         cfg_i,
  cbpa_req_if         req_i,
  cbpa_rsp_if         rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned POOL_CAP   = DEFAULT_CAPACITY;
  localparam int unsigned POOL_GROW  = DEFAULT_GROW_BATCH;
  localparam int unsigned POOL_HDR   = DEFAULT_HEADER_BYTES;
  localparam int unsigned POOL_LINE  = 1 << LINE_SHIFT;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   block_address;
    logic [COUNT_W-1:0]  free_blocks;
    logic [COUNT_W-1:0]  in_use_blocks;
    logic [COUNT_W-1:0]  provisioned_blocks;
  } pool_rsp_t;

  logic [PAYLOAD_W-1:0] payload_q;
  logic [COUNT_W-1:0]   limit_q;
  logic [COUNT_W-1:0]   initial_q;
  bit                   mark_q [POOL_CAP];
  logic [9:0]           link_q [POOL_CAP];
  logic [9:0]           head_q;
  logic [COUNT_W-1:0]   depth_q;
  logic [COUNT_W-1:0]   fresh_q;
  logic [COUNT_W-1:0]   prov_q;
  logic [COUNT_W-1:0]   free_q;
  pool_rsp_t            expected_rsps [$];

  function automatic int unsigned pool_limit();
    if (limit_q == '0 || limit_q > POOL_CAP) return POOL_CAP;
    return 32'(limit_q);
  endfunction

  function automatic longint unsigned pool_stride();
    return ((longint'(POOL_HDR) + payload_q + POOL_LINE - 1) / POOL_LINE) * POOL_LINE;
  endfunction

  function automatic void restart_pool();
    int unsigned lim;
    lim = pool_limit();
    foreach (mark_q[i]) mark_q[i] = 1'b0;
    head_q  = '0;
    depth_q = '0;
    fresh_q = '0;
    prov_q  = (initial_q < lim) ? initial_q : COUNT_W'(lim);
    free_q  = prov_q;
  endfunction

  function automatic pool_rsp_t predict_pool(logic act, logic [SIZE_W-1:0] size,
                                             logic [ADDR_W-1:0] addr);
    pool_rsp_t         r;
    int unsigned       lim;
    int unsigned       grow;
    int unsigned       idx;
    bit                got_block;
    longint unsigned   stride;
    longint unsigned   off;
    longint unsigned   blk;
    r        = '0;
    r.status = ST_OK;
    lim      = pool_limit();
    stride   = pool_stride();
    if (act == ACT_ALLOC) begin
      if (size > payload_q) begin
        r.status = ST_TOO_LARGE;
      end else begin
        if (depth_q == '0 && fresh_q >= prov_q && prov_q < lim) begin
          grow = lim - 32'(prov_q);
          if (grow > POOL_GROW) grow = POOL_GROW;
          prov_q = prov_q + COUNT_W'(grow);
          free_q = free_q + COUNT_W'(grow);
        end
        got_block = 1'b1;
        if (depth_q != '0) begin
          idx     = 32'(head_q);
          head_q  = link_q[idx];
          depth_q = depth_q - COUNT_W'(1);
        end else if (fresh_q < prov_q) begin
          idx     = 32'(fresh_q);
          fresh_q = fresh_q + COUNT_W'(1);
        end else begin
          got_block = 1'b0;
          r.status  = ST_EXHAUSTED;
        end
        if (got_block) begin
          mark_q[idx]     = 1'b1;
          free_q          = free_q - COUNT_W'(1);
          blk             = longint'(idx) * stride + 64'(POOL_HDR);
          r.block_address = ADDR_W'(blk);
        end
      end
    end else begin
      if (addr < POOL_HDR) begin
        r.status = ST_BAD_ADDR;
      end else begin
        off = 64'(addr) - 64'(POOL_HDR);
        if (off % stride != 0 || off / stride >= prov_q) begin
          r.status = ST_BAD_ADDR;
        end else begin
          idx = 32'(off / stride);
          if (!mark_q[idx]) begin
            r.status = ST_DOUBLE_FREE;
          end else begin
            mark_q[idx] = 1'b0;
            link_q[idx] = head_q;
            head_q      = 10'(idx);
            depth_q     = depth_q + COUNT_W'(1);
            free_q      = free_q + COUNT_W'(1);
          end
        end
      end
    end
    r.free_blocks        = free_q;
    r.in_use_blocks      = prov_q - free_q;
    r.provisioned_blocks = prov_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pool_rsp_t seen;
    pool_rsp_t want;
    if (!rst_ni) begin
      payload_q = PAYLOAD_W'(RESET_PAYLOAD_BYTES);
      limit_q   = '0;
      initial_q = '0;
      foreach (link_q[i]) link_q[i] = '0;
      restart_pool();
      expected_rsps.delete();
      fail_count_o = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        seen = {rsp_i.status, rsp_i.block_address, rsp_i.free_blocks,
                rsp_i.in_use_blocks, rsp_i.provisioned_blocks};
        if (expected_rsps.size() == 0) begin
          if (fail_count_o < REPORT_MAX)
            $display("%0t: response with none outstanding: status %0d addr 0x%06h",
                     $time, seen.status, seen.block_address);
          fail_count_o++;
        end else begin
          want = expected_rsps.pop_front();
          if (seen !== want) begin
            if (fail_count_o < REPORT_MAX)
              $display({"%0t: mismatch: expected status %0d addr 0x%06h free %0d ",
                        "in use %0d prov %0d, got status %0d addr 0x%06h free %0d ",
                        "in use %0d prov %0d"}, $time,
                       want.status, want.block_address, want.free_blocks,
                       want.in_use_blocks, want.provisioned_blocks,
                       seen.status, seen.block_address, seen.free_blocks,
                       seen.in_use_blocks, seen.provisioned_blocks);
            fail_count_o++;
          end
        end
      end
      if (req_i.valid && req_i.ready)
        expected_rsps.push_back(predict_pool(req_i.action, req_i.request_size,
                                             req_i.address));
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_PAYLOAD_BYTES: begin
            payload_q = cfg_i.data;
            restart_pool();
          end
          CFG_BLOCK_LIMIT: begin
            limit_q = cfg_i.data[COUNT_W-1:0];
            restart_pool();
          end
          CFG_INITIAL_BLOCKS: begin
            initial_q = cfg_i.data[COUNT_W-1:0];
            restart_pool();
          end
          default: begin
          end
        endcase
      end
    end
    pending_o = expected_rsps.size();
  end

endmodule

FILE: test/tb_checked_block_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool allocator testbench
// Drives directed and random allocate and free requests through several pool
// settings with random sender gaps and receiver stalls; the checker beside
// the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_checked_block_pool_allocator;
  import cbpa_pkg::*;

  localparam int unsigned CLK_HALF      = 6;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned HDR           = DEFAULT_HEADER_BYTES;
  localparam int unsigned ADDR_TOP      = (1 << ADDR_W) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       cycle_count = 0;
  int unsigned       cur_payload;
  int unsigned       burst_left = 0;
  int unsigned       pattern_age = 0;
  logic [15:0]       ready_pattern = 16'hFFFF;
  logic [ADDR_W-1:0] live_addrs [$];
  logic [ADDR_W-1:0] last_freed = '0;

  cbpa_cfg_if cfg_ch ();
  cbpa_req_if req_ch ();
  cbpa_rsp_if rsp_ch ();

  checked_block_pool_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  cbpa_pool_checker u_pool_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_ch),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The receiver follows a rotating ready pattern that is redrawn now and then.
  always @(negedge clk_i) begin
    rsp_ch.ready  = ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    pattern_age++;
    if (pattern_age == 97) begin
      pattern_age = 0;
      case ($urandom_range(0, 3))
        0:       ready_pattern = '1;
        1:       ready_pattern = 16'($urandom);
        2:       ready_pattern = 16'($urandom | $urandom);
        default: ready_pattern = 16'h0101;
      endcase
      if (ready_pattern == '0) ready_pattern = 16'h8000;
    end
  end

  // Addresses handed out are kept so that most frees hit live blocks.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == ST_OK &&
        rsp_ch.block_address != '0)
      live_addrs.push_back(rsp_ch.block_address);
  end

  function automatic int unsigned block_stride();
    return ((HDR + cur_payload + 63) / 64) * 64;
  endfunction

  task automatic send_req(logic act, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_ch.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    req_ch.action       = act;
    req_ch.request_size = size;
    req_ch.address      = addr;
    req_ch.valid        = 1'b1;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic alloc_item(int unsigned size);
    send_req(ACT_ALLOC, SIZE_W'(size), ADDR_W'($urandom));
  endtask

  task automatic free_item(int unsigned addr);
    send_req(ACT_FREE, SIZE_W'($urandom), ADDR_W'(addr));
  endtask

  task automatic wait_drained();
    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_ch.index = idx;
    cfg_ch.data  = CFG_DATA_W'(value);
    cfg_ch.valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_pool(int unsigned payload, int unsigned limit, int unsigned initial_n,
                          bit spare_write);
    wait_drained();
    write_reg(CFG_PAYLOAD_BYTES, payload);
    write_reg(CFG_BLOCK_LIMIT, limit);
    write_reg(CFG_INITIAL_BLOCKS, initial_n);
    if (spare_write) write_reg(CFG_NO_REG, $urandom);
    cfg_ch.valid = 1'b0;
    cur_payload  = payload & 12'hFFF;
    live_addrs.delete();
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned k;
    int unsigned stride;
    int unsigned idx;
    pick   = $urandom_range(0, 99);
    stride = block_stride();
    idx    = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 1100);
    if (pick >= 52 && pick < 88 && live_addrs.size() != 0) begin
      k          = $urandom_range(0, live_addrs.size() - 1);
      last_freed = live_addrs[k];
      live_addrs.delete(k);
      free_item(last_freed);
    end else if (pick >= 88) begin
      case ($urandom_range(0, 4))
        0:       free_item($urandom_range(0, ADDR_TOP));
        1:       free_item($urandom_range(0, HDR - 1));
        2:       free_item(HDR + stride * idx);
        3:       free_item(HDR + stride * $urandom_range(0, 40) + $urandom_range(1, stride - 1));
        default: free_item(last_freed);
      endcase
    end else if (pick >= 45 && pick < 52) begin
      alloc_item($urandom_range(cur_payload + 1, 65535));
    end else begin
      alloc_item($urandom_range(0, cur_payload));
    end
  endtask

  initial begin
    int unsigned stride;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    req_ch.valid        = 1'b0;
    req_ch.action       = ACT_ALLOC;
    req_ch.request_size = '0;
    req_ch.address      = '0;
    rsp_ch.ready        = 1'b0;
    cur_payload         = RESET_PAYLOAD_BYTES;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings give a stride of 128 bytes.
    alloc_item(0);
    alloc_item(64);
    alloc_item(65);
    alloc_item(65535);
    free_item(64);
    free_item(64);
    free_item(0);
    free_item(63);
    free_item(100);
    free_item(HDR + 128 * 32);
    free_item(HDR + 128 * 5);
    free_item(ADDR_TOP);
    alloc_item(1);
    free_item(192);
    free_item(64);
    alloc_item(10);
    alloc_item(20);

    // A single block pool runs out at once.
    set_pool(1, 1, 0, 1'b1);
    alloc_item(1);
    alloc_item(2);
    alloc_item(0);
    free_item(64);
    free_item(64);
    alloc_item(0);

    // A limit that is not a whole number of growth batches.
    set_pool(4032, 40, 0, 1'b0);
    repeat (41) alloc_item($urandom_range(0, 4032));

    // The largest payload gives the widest stride and the largest quotients.
    set_pool(4095, 0, 1024, 1'b0);
    stride = block_stride();
    repeat (40) alloc_item($urandom_range(0, 4095));
    free_item(HDR + 1008 * stride);
    free_item((HDR + 1009 * stride) & ADDR_TOP);
    free_item(HDR);
    alloc_item(4095);
    alloc_item(0);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_pool(4032, 20, 100, 1'b0);
        1: set_pool($urandom_range(1, 200), 12'hFFF, $urandom_range(0, 40), 1'b1);
        2: set_pool($urandom_range(1, 4095), $urandom_range(2, 70), $urandom_range(0, 70), 1'b0);
        3: set_pool(1, 1024, 0, 1'b1);
        4: set_pool($urandom_range(1, 600), $urandom_range(33, 64), 0, 1'b0);
        default: set_pool($urandom_range(1, 4095), 0, $urandom_range(0, 4095), 1'b1);
      endcase
      for (int n = 0; n < 70; n++) begin
        if (n == 35 && phase % 2 == 1) wait_drained();
        random_item();
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
